// ===== rtl/core/lldt_pkg.sv =====
package lldt_pkg;

  // fixed widths of the transaction fields
  localparam int MODE_W   = 3;
  localparam int VALUE_W  = 16;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;
  localparam int SIZE_W   = 5;

  // operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 3'd0,
    MODE_FIND   = 3'd1,
    MODE_DELETE = 3'd2,
    MODE_PURGE  = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  // commands from the sequencer to the scan unit
  typedef struct packed {
    logic load;
    logic run;
    logic keep;
  } walk_ctl_t;

  // flags from the scan unit for the entry under compare
  typedef struct packed {
    logic vld;
    logic live;
    logic match;
    logic last;
  } walk_sts_t;

endpackage

// ===== rtl/core/lldt_ram.sv =====
module lldt_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/lldt_walk.sv =====
module lldt_walk #(
  parameter int DEPTH = 16,
  parameter int VALUE_WIDTH = 16,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lldt_pkg::walk_ctl_t   ctl,
  input  logic [AW-1:0]         head,
  input  logic [CW-1:0]         occ,
  input  logic [VALUE_WIDTH-1:0] key,
  input  logic [VALUE_WIDTH:0]  rd_data,
  output logic [AW-1:0]         rd_addr,
  output lldt_pkg::walk_sts_t   sts,
  output logic [AW-1:0]         cmp_ptr,
  output logic [AW-1:0]         cmp_idx,
  output logic [AW-1:0]         wr_ptr,
  output logic [CW-1:0]         kept_cnt
);

  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] wr_cnt;
  logic          cmp_vld;
  logic          issue;

  // circular slot pointer step
  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // read one occupied slot per cycle, front to back
  assign issue   = ctl.run && (rd_idx < occ);
  assign rd_addr = rd_ptr;

  // read pointer, compare stage and compaction write pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr  <= '0;
      rd_idx  <= '0;
      cmp_vld <= 1'b0;
      wr_ptr  <= '0;
      wr_cnt  <= '0;
    end else if (ctl.load) begin
      rd_ptr  <= head;
      rd_idx  <= '0;
      cmp_vld <= 1'b0;
      wr_ptr  <= head;
      wr_cnt  <= '0;
    end else begin
      cmp_vld <= issue;
      if (issue) begin
        cmp_ptr <= rd_ptr;
        cmp_idx <= rd_idx[AW-1:0];
        rd_ptr  <= ptr_inc(rd_ptr);
        rd_idx  <= rd_idx + 1'b1;
      end
      if (ctl.keep) begin
        wr_ptr <= ptr_inc(wr_ptr);
        wr_cnt <= wr_cnt + 1'b1;
      end
    end
  end

  // shared compare on the returned slot
  always_comb begin
    sts.vld   = cmp_vld;
    sts.live  = ~rd_data[VALUE_WIDTH];
    sts.match = (rd_data[VALUE_WIDTH-1:0] == key);
    sts.last  = ((CW'(cmp_idx) + CW'(1)) == occ);
  end

  assign kept_cnt = wr_cnt + CW'(ctl.keep);

endmodule

// ===== rtl/core/lazy_delete_list_table_unit.sv =====
// Ordered store of up to DEPTH values, newest first, with lazy deletion.
// Command channel: a transaction is taken at a rising edge with start high
// and busy low; mode selects insert, find, lazy delete, purge or clear and
// value carries the key. Each transaction gives exactly one result, shown
// on status, found, position, logical_size and physical_size for the one
// cycle in which done is high.
// Insert, clear, unused modes, find or delete with no live entry and purge
// with no occupied slot answer without a walk, done in the cycle after the
// accept edge. Find and delete walk the slots front to back, one per cycle,
// through the single read port of the slot memory and stop at the first
// live match. Purge walks all occupied slots, compacting live ones in place.
// busy is high for the whole walk; a new transaction may be started in the
// cycle done is high. The receiver cannot stall, so results are never held.
// Reset empties the store at once: both counts clear, stored values need
// no clearing because only occupied slots are ever read.
module lazy_delete_list_table_unit #(
  parameter int DEPTH = 16,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [lldt_pkg::MODE_W-1:0]  mode,
  input  logic [lldt_pkg::VALUE_W-1:0] value,
  output logic                         done,
  output logic [lldt_pkg::STATUS_W-1:0] status,
  output logic                         found,
  output logic [lldt_pkg::POS_W-1:0]   position,
  output logic [lldt_pkg::SIZE_W-1:0]  logical_size,
  output logic [lldt_pkg::SIZE_W-1:0]  physical_size
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = lldt_pkg::POS_W;
  localparam int SW = lldt_pkg::SIZE_W;

  lldt_pkg::state_t    state, state_next;
  lldt_pkg::walk_ctl_t ctl;
  lldt_pkg::walk_sts_t sts;

  logic [lldt_pkg::MODE_W-1:0] op;
  logic [VALUE_WIDTH-1:0]      key;
  logic [VALUE_WIDTH-1:0]      key_in;
  logic [AW-1:0]               head;
  logic [AW-1:0]               head_dec;
  logic [CW-1:0]               occ;
  logic [CW-1:0]               live;
  logic [CW-1:0]               kept_cnt;
  logic [AW-1:0]               cmp_ptr;
  logic [AW-1:0]               cmp_idx;
  logic [AW-1:0]               wr_ptr;
  logic [AW-1:0]               rd_addr;
  logic [VALUE_WIDTH:0]        rd_data;
  logic                        ram_wr_en;
  logic [AW-1:0]               ram_wr_addr;
  logic [VALUE_WIDTH:0]        ram_wr_data;
  logic                        accept;
  logic                        to_scan;
  logic                        full;
  logic                        search;
  logic                        hit;
  logic                        finish;

  assign busy     = (state != lldt_pkg::ST_IDLE);
  assign accept   = start && !busy;
  assign key_in   = VALUE_WIDTH'(value);
  assign full     = (occ == CW'(DEPTH));
  assign head_dec = (head == '0) ? AW'(DEPTH - 1) : head - 1'b1;
  assign search   = (op == lldt_pkg::MODE_FIND) || (op == lldt_pkg::MODE_DELETE);

  // which commands need a walk over the slots
  always_comb begin
    unique case (mode) inside
      lldt_pkg::MODE_FIND, lldt_pkg::MODE_DELETE: to_scan = (live != '0);
      lldt_pkg::MODE_PURGE:                       to_scan = (occ != '0);
      default:                                    to_scan = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lldt_pkg::ST_IDLE: if (accept && to_scan) state_next = lldt_pkg::ST_SCAN;
      lldt_pkg::ST_SCAN: if (finish) state_next = lldt_pkg::ST_IDLE;
      default:           state_next = lldt_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: scan commands and slot memory writes
  always_comb begin
    ctl.load    = accept;
    ctl.run     = (state == lldt_pkg::ST_SCAN);
    ctl.keep    = ctl.run && (op == lldt_pkg::MODE_PURGE) && sts.vld && sts.live;
    hit         = ctl.run && search && sts.vld && sts.live && sts.match;
    finish      = ctl.run && sts.vld && (hit || sts.last);
    ram_wr_en   = 1'b0;
    ram_wr_addr = head_dec;
    ram_wr_data = {1'b0, key_in};
    if (accept && (mode == lldt_pkg::MODE_INSERT) && !full) begin
      ram_wr_en = 1'b1;
    end else if (hit && (op == lldt_pkg::MODE_DELETE)) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = cmp_ptr;
      ram_wr_data = {1'b1, key};
    end else if (ctl.keep) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = wr_ptr;
      ram_wr_data = {1'b0, rd_data[VALUE_WIDTH-1:0]};
    end
  end

  // counts, front pointer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lldt_pkg::ST_IDLE;
      done  <= 1'b0;
      head  <= '0;
      occ   <= '0;
      live  <= '0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (accept) begin
        op       <= mode;
        key      <= key_in;
        done     <= !to_scan;
        found    <= 1'b0;
        position <= '0;
        status   <= lldt_pkg::STAT_OK;
        unique case (mode) inside
          lldt_pkg::MODE_INSERT: begin
            if (full) begin
              status <= lldt_pkg::STAT_FULL;
            end else begin
              head <= head_dec;
              occ  <= occ + 1'b1;
              live <= live + 1'b1;
            end
          end
          lldt_pkg::MODE_FIND, lldt_pkg::MODE_DELETE: begin
            if (live == '0) status <= lldt_pkg::STAT_EMPTY;
          end
          lldt_pkg::MODE_CLEAR: begin
            occ  <= '0;
            live <= '0;
          end
          default: begin
          end
        endcase
      end else if (finish) begin
        done     <= 1'b1;
        found    <= hit;
        position <= hit ? PW'(cmp_idx) : '0;
        status   <= (search && !hit) ? lldt_pkg::STAT_NOT_FOUND : lldt_pkg::STAT_OK;
        if (hit && (op == lldt_pkg::MODE_DELETE)) live <= live - 1'b1;
        if (op == lldt_pkg::MODE_PURGE) begin
          occ  <= kept_cnt;
          live <= kept_cnt;
        end
      end
    end
  end

  assign logical_size  = SW'(live);
  assign physical_size = SW'(occ);

  // slot memory: value with its deleted mark on top
  lldt_ram #(
    .WIDTH (VALUE_WIDTH + 1),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // shared scan unit
  lldt_walk #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_walk (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .head     (head),
    .occ      (occ),
    .key      (key),
    .rd_data  (rd_data),
    .rd_addr  (rd_addr),
    .sts      (sts),
    .cmp_ptr  (cmp_ptr),
    .cmp_idx  (cmp_idx),
    .wr_ptr   (wr_ptr),
    .kept_cnt (kept_cnt)
  );

  // live entries are a subset of stored ones
  assert property (@(posedge clk) disable iff (rst) live <= occ)
    else $error("live count exceeds occupied count");

  // store never overfills
  assert property (@(posedge clk) disable iff (rst) occ <= CW'(DEPTH))
    else $error("occupied count exceeds depth");

  // end of a walk always gives a result
  assert property (@(posedge clk) disable iff (rst)
    (state == lldt_pkg::ST_SCAN && state_next == lldt_pkg::ST_IDLE) |=> done)
    else $error("walk ended without a result");

  // a walk starts busy and without a result
  assert property (@(posedge clk) disable iff (rst)
    (accept && to_scan) |=> (busy && !done))
    else $error("walk start produced an early result");

  // an accepted insert grows the store by one
  assert property (@(posedge clk) disable iff (rst)
    (accept && mode == lldt_pkg::MODE_INSERT && !full) |=> (occ == $past(occ) + CW'(1)))
    else $error("insert did not grow the store");

endmodule
